// ----- sv/mdp_pkg.sv -----
// shared types, character codes and result codes of the method descriptor parser
package mdp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned BTYPE_W = 4;
    localparam int unsigned ERR_W   = 3;

    localparam int unsigned MAX_PARAMS_DEF      = 255;
    localparam int unsigned MAX_NAME_CHARS_DEF  = 253;
    localparam int unsigned MAX_ARRAY_DEPTH_DEF = 255;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;  // (
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;  // )
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;  // ;
    localparam logic [CHAR_W-1:0] CH_ARRAY = 8'h5B;  // [
    localparam logic [CHAR_W-1:0] CH_CLASS = 8'h4C;  // L
    localparam logic [CHAR_W-1:0] CH_VOID  = 8'h56;  // V
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
    localparam logic [CHAR_W-1:0] CH_J     = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    // character classes
    typedef logic [2:0] kind_t;
    localparam kind_t K_OPEN  = 3'd0;
    localparam kind_t K_CLOSE = 3'd1;
    localparam kind_t K_VOID  = 3'd2;
    localparam kind_t K_SEMI  = 3'd3;
    localparam kind_t K_CLASS = 3'd4;
    localparam kind_t K_ARRAY = 3'd5;
    localparam kind_t K_PRIM  = 3'd6;
    localparam kind_t K_OTHER = 3'd7;

    // classified request passed from front to back
    typedef struct packed {
        kind_t                kind;
        logic [BTYPE_W-1:0]   prim;
        logic                 eot;
    } item_t;

    // event codes
    localparam logic [EVENT_W-1:0] EV_CONT  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PARAM = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RET   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_ERR   = 2'd3;

    // base types
    localparam logic [BTYPE_W-1:0] BT_BYTE    = 4'd0;
    localparam logic [BTYPE_W-1:0] BT_CHAR    = 4'd1;
    localparam logic [BTYPE_W-1:0] BT_DOUBLE  = 4'd2;
    localparam logic [BTYPE_W-1:0] BT_FLOAT   = 4'd3;
    localparam logic [BTYPE_W-1:0] BT_INT     = 4'd4;
    localparam logic [BTYPE_W-1:0] BT_LONG    = 4'd5;
    localparam logic [BTYPE_W-1:0] BT_SHORT   = 4'd6;
    localparam logic [BTYPE_W-1:0] BT_BOOLEAN = 4'd7;
    localparam logic [BTYPE_W-1:0] BT_CLASS   = 4'd8;
    localparam logic [BTYPE_W-1:0] BT_VOID    = 4'd9;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_OPEN   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NAME_LONG = 3'd3;
    localparam logic [ERR_W-1:0] ERR_PARAMS    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_DEEP      = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TRAILING  = 3'd6;
    localparam logic [ERR_W-1:0] ERR_EARLY     = 3'd7;

endpackage

// ----- sv/mdp_front.sv -----
// front end: input handshake and character classification
module mdp_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mdp_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                        s_end_of_text,
    input  logic                        q_full,
    output logic                        q_push,
    output mdp_pkg::item_t              q_item
);

    always_comb begin
        q_item.eot  = s_end_of_text;
        q_item.prim = mdp_pkg::BT_BYTE;
        q_item.kind = mdp_pkg::K_PRIM;
        case (s_char_code)
            mdp_pkg::CH_OPEN:  q_item.kind = mdp_pkg::K_OPEN;
            mdp_pkg::CH_CLOSE: q_item.kind = mdp_pkg::K_CLOSE;
            mdp_pkg::CH_VOID:  q_item.kind = mdp_pkg::K_VOID;
            mdp_pkg::CH_SEMI:  q_item.kind = mdp_pkg::K_SEMI;
            mdp_pkg::CH_CLASS: q_item.kind = mdp_pkg::K_CLASS;
            mdp_pkg::CH_ARRAY: q_item.kind = mdp_pkg::K_ARRAY;
            mdp_pkg::CH_B:     q_item.prim = mdp_pkg::BT_BYTE;
            mdp_pkg::CH_C:     q_item.prim = mdp_pkg::BT_CHAR;
            mdp_pkg::CH_D:     q_item.prim = mdp_pkg::BT_DOUBLE;
            mdp_pkg::CH_F:     q_item.prim = mdp_pkg::BT_FLOAT;
            mdp_pkg::CH_I:     q_item.prim = mdp_pkg::BT_INT;
            mdp_pkg::CH_J:     q_item.prim = mdp_pkg::BT_LONG;
            mdp_pkg::CH_S:     q_item.prim = mdp_pkg::BT_SHORT;
            mdp_pkg::CH_Z:     q_item.prim = mdp_pkg::BT_BOOLEAN;
            default:           q_item.kind = mdp_pkg::K_OTHER;
        endcase
    end

    assign s_ready = ~q_full;
    assign q_push  = s_valid & ~q_full;

endmodule

// ----- sv/mdp_queue.sv -----
// small fifo of classified requests between front and back
module mdp_queue #(
    parameter int unsigned DEPTH = mdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mdp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mdp_pkg::item_t  head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mdp_pkg::item_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/mdp_back.sv -----
// back end: grammar state machine, counters and result register
module mdp_back #(
    parameter int unsigned MAX_PARAMS      = mdp_pkg::MAX_PARAMS_DEF,
    parameter int unsigned MAX_NAME_CHARS  = mdp_pkg::MAX_NAME_CHARS_DEF,
    parameter int unsigned MAX_ARRAY_DEPTH = mdp_pkg::MAX_ARRAY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_not_empty,
    input  mdp_pkg::item_t                  q_item,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mdp_pkg::EVENT_W-1:0]     m_event_res,
    output logic [mdp_pkg::BTYPE_W-1:0]     m_base_type,
    output logic [mdp_pkg::COUNT_W-1:0]     m_array_depth,
    output logic [mdp_pkg::COUNT_W-1:0]     m_param_index,
    output logic [mdp_pkg::COUNT_W-1:0]     m_name_length,
    output logic [mdp_pkg::ERR_W-1:0]       m_error_code
);

    localparam int unsigned CW = mdp_pkg::COUNT_W;

    localparam logic [2:0] PH_OPEN   = 3'd0;
    localparam logic [2:0] PH_PARAMS = 3'd1;
    localparam logic [2:0] PH_PNAME  = 3'd2;
    localparam logic [2:0] PH_RET    = 3'd3;
    localparam logic [2:0] PH_RNAME  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_ERR    = 3'd6;

    localparam logic [CW-1:0] LIM_PARAMS = CW'(MAX_PARAMS);
    localparam logic [CW-1:0] LIM_NAME   = CW'(MAX_NAME_CHARS);
    localparam logic [CW-1:0] LIM_DEPTH  = CW'(MAX_ARRAY_DEPTH);

    logic [2:0]                     phase_reg, phase_next;
    logic [CW-1:0]                  bracket_reg, bracket_next;
    logic [CW-1:0]                  pcount_reg, pcount_next;
    logic [CW-1:0]                  nlen_reg, nlen_next;
    logic [mdp_pkg::ERR_W-1:0]      held_reg, held_next;

    logic                           out_valid_reg;
    logic [mdp_pkg::EVENT_W-1:0]    ev_reg, ev_next;
    logic [mdp_pkg::BTYPE_W-1:0]    bt_reg, bt_next;
    logic [CW-1:0]                  depth_reg, depth_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  len_reg, len_next;
    logic [mdp_pkg::ERR_W-1:0]      err_reg, err_next;

    logic                           is_ret, do_type, do_name, do_finish, do_fail;
    logic [mdp_pkg::BTYPE_W-1:0]    fin_bt;
    logic [CW-1:0]                  fin_len;
    logic [mdp_pkg::ERR_W-1:0]      fail_code;

    assign q_pop  = q_not_empty & (~out_valid_reg | m_ready);
    assign is_ret = (phase_reg == PH_RET) || (phase_reg == PH_RNAME);

    always_comb begin
        phase_next   = phase_reg;
        bracket_next = bracket_reg;
        pcount_next  = pcount_reg;
        nlen_next    = nlen_reg;
        held_next    = held_reg;
        ev_next      = mdp_pkg::EV_CONT;
        bt_next      = '0;
        depth_next   = '0;
        idx_next     = '0;
        len_next     = '0;
        err_next     = mdp_pkg::ERR_NONE;
        do_type      = 1'b0;
        do_name      = 1'b0;
        do_finish    = 1'b0;
        do_fail      = 1'b0;
        fin_bt       = '0;
        fin_len      = '0;
        fail_code    = mdp_pkg::ERR_NONE;

        case (phase_reg)
            PH_OPEN: begin
                if (q_item.kind == mdp_pkg::K_OPEN) begin
                    phase_next = PH_PARAMS;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = mdp_pkg::ERR_NO_OPEN;
                end
            end
            PH_PARAMS: begin
                if (q_item.kind == mdp_pkg::K_CLOSE) begin
                    if (bracket_reg != '0) begin
                        do_fail   = 1'b1;
                        fail_code = mdp_pkg::ERR_BAD_CHAR;
                    end else begin
                        phase_next = PH_RET;
                    end
                end else begin
                    do_type = 1'b1;
                end
            end
            PH_RET: begin
                if (q_item.kind == mdp_pkg::K_VOID) begin
                    if (bracket_reg != '0) begin
                        do_fail   = 1'b1;
                        fail_code = mdp_pkg::ERR_BAD_CHAR;
                    end else begin
                        do_finish = 1'b1;
                        fin_bt    = mdp_pkg::BT_VOID;
                    end
                end else begin
                    do_type = 1'b1;
                end
            end
            PH_PNAME, PH_RNAME: begin
                do_name = 1'b1;
            end
            PH_DONE: begin
                do_fail   = 1'b1;
                fail_code = mdp_pkg::ERR_TRAILING;
            end
            default: begin
                phase_next = PH_ERR;
                ev_next    = mdp_pkg::EV_ERR;
                err_next   = held_reg;
            end
        endcase

        // start of a field type
        if (do_type) begin
            if (q_item.kind == mdp_pkg::K_PRIM) begin
                do_finish = 1'b1;
                fin_bt    = q_item.prim;
            end else if (q_item.kind == mdp_pkg::K_ARRAY) begin
                if (bracket_reg >= LIM_DEPTH) begin
                    do_fail   = 1'b1;
                    fail_code = mdp_pkg::ERR_DEEP;
                end else begin
                    bracket_next = bracket_reg + 1'b1;
                end
            end else if (q_item.kind == mdp_pkg::K_CLASS) begin
                nlen_next  = '0;
                phase_next = is_ret ? PH_RNAME : PH_PNAME;
            end else begin
                do_fail   = 1'b1;
                fail_code = mdp_pkg::ERR_BAD_CHAR;
            end
        end

        // class name bytes up to the semicolon
        if (do_name) begin
            if (q_item.kind == mdp_pkg::K_SEMI) begin
                if (nlen_reg == '0) begin
                    do_fail   = 1'b1;
                    fail_code = mdp_pkg::ERR_BAD_CHAR;
                end else begin
                    do_finish = 1'b1;
                    fin_bt    = mdp_pkg::BT_CLASS;
                    fin_len   = nlen_reg;
                end
            end else if (nlen_reg >= LIM_NAME) begin
                do_fail   = 1'b1;
                fail_code = mdp_pkg::ERR_NAME_LONG;
            end else begin
                nlen_next = nlen_reg + 1'b1;
            end
        end

        // a type is complete
        if (do_finish) begin
            if (!is_ret && (pcount_reg >= LIM_PARAMS)) begin
                do_fail   = 1'b1;
                fail_code = mdp_pkg::ERR_PARAMS;
            end else begin
                ev_next      = is_ret ? mdp_pkg::EV_RET : mdp_pkg::EV_PARAM;
                bt_next      = fin_bt;
                depth_next   = bracket_reg;
                idx_next     = is_ret ? '0 : pcount_reg;
                len_next     = fin_len;
                phase_next   = is_ret ? PH_DONE : PH_PARAMS;
                pcount_next  = is_ret ? pcount_reg : pcount_reg + 1'b1;
                bracket_next = '0;
                nlen_next    = '0;
            end
        end

        if (do_fail) begin
            phase_next = PH_ERR;
            held_next  = fail_code;
            ev_next    = mdp_pkg::EV_ERR;
            err_next   = fail_code;
        end

        // end of text: report an early end unless finished or failed, and return to reset state
        if (q_item.eot) begin
            if (phase_next != PH_DONE && phase_next != PH_ERR) begin
                ev_next    = mdp_pkg::EV_ERR;
                bt_next    = '0;
                depth_next = '0;
                idx_next   = '0;
                len_next   = '0;
                err_next   = mdp_pkg::ERR_EARLY;
            end
            phase_next   = PH_OPEN;
            bracket_next = '0;
            pcount_next  = '0;
            nlen_next    = '0;
            held_next    = mdp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPEN;
            bracket_reg   <= '0;
            pcount_reg    <= '0;
            nlen_reg      <= '0;
            held_reg      <= mdp_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                bracket_reg   <= bracket_next;
                pcount_reg    <= pcount_next;
                nlen_reg      <= nlen_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ev_reg    <= ev_next;
            bt_reg    <= bt_next;
            depth_reg <= depth_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_res   = ev_reg;
    assign m_base_type   = bt_reg;
    assign m_array_depth = depth_reg;
    assign m_param_index = idx_reg;
    assign m_name_length = len_reg;
    assign m_error_code  = err_reg;

endmodule

// ----- sv/method_descriptor_parser.sv -----
// top level of the method descriptor parser
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_char_code, s_end_of_text
//  m_        out        m_valid / m_ready  m_event_res, m_base_type, m_array_depth,
//                                          m_param_index, m_name_length, m_error_code
//
// one request per cycle sustained while m_ready stays high; each character gives exactly one result
// with an empty queue a request is written into the fifo at the accepting edge
// and from there into the result register, which raises m_valid
// aresetn is synchronous, active low; it clears the grammar state, counters and queue
// the front stalls only when the queue is full, the back only when a result waits
// on m_ready, so either side may stall without blocking the other at once
module method_descriptor_parser #(
    parameter int unsigned MAX_PARAMS      = mdp_pkg::MAX_PARAMS_DEF,
    parameter int unsigned MAX_NAME_CHARS  = mdp_pkg::MAX_NAME_CHARS_DEF,
    parameter int unsigned MAX_ARRAY_DEPTH = mdp_pkg::MAX_ARRAY_DEPTH_DEF,
    parameter int unsigned QUEUE_DEPTH     = mdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input characters
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mdp_pkg::CHAR_W-1:0]      s_char_code,
    input  logic                            s_end_of_text,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mdp_pkg::EVENT_W-1:0]     m_event_res,
    output logic [mdp_pkg::BTYPE_W-1:0]     m_base_type,
    output logic [mdp_pkg::COUNT_W-1:0]     m_array_depth,
    output logic [mdp_pkg::COUNT_W-1:0]     m_param_index,
    output logic [mdp_pkg::COUNT_W-1:0]     m_name_length,
    output logic [mdp_pkg::ERR_W-1:0]       m_error_code
);

    // classified request travelling from the front to the back
    mdp_pkg::item_t front_item;
    mdp_pkg::item_t head_item;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;

    // front: handshake and character classification, no state of its own
    mdp_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (front_item)
    );

    // decoupling queue
    mdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // back: grammar phases, bracket/parameter/name counters, result register
    mdp_back #(
        .MAX_PARAMS      (MAX_PARAMS),
        .MAX_NAME_CHARS  (MAX_NAME_CHARS),
        .MAX_ARRAY_DEPTH (MAX_ARRAY_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_base_type   (m_base_type),
        .m_array_depth (m_array_depth),
        .m_param_index (m_param_index),
        .m_name_length (m_name_length),
        .m_error_code  (m_error_code)
    );

endmodule

// ----- sim/tb_method_descriptor_parser.sv -----
// self-checking testbench of the method descriptor parser: directed table, then random descriptors
module tb_method_descriptor_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mdp_pkg::*;

    // run shape
    localparam int unsigned RANDOM_CHARS   = 1250;  // ordinary random characters
    localparam int unsigned MAX_GAP        = 13;    // longest idle gap of either side
    localparam int unsigned HOLD_AFTER     = 300;   // results seen before the long stall
    localparam int unsigned LONG_HOLD      = 300;   // cycles the receiver holds off once
    localparam int unsigned DRAIN_CYCLES   = 8;     // extra wait after the last owed result
    localparam int unsigned WATCHDOG_LIMIT = 1500;  // cycles with no request or result moving

    // grammar phases of the predictor
    typedef enum logic [2:0] {
        PHASE_OPEN,
        PHASE_PARAMS,
        PHASE_PNAME,
        PHASE_RET,
        PHASE_RNAME,
        PHASE_DONE,
        PHASE_ERR
    } grammar_phase_e;

    // one result as the block reports it
    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [BTYPE_W-1:0] bt;
        logic [COUNT_W-1:0] depth;
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W-1:0] nlen;
        logic [ERR_W-1:0]   err;
    } result_t;

    // one request: a descriptor byte and its end mark
    typedef struct packed {
        logic [CHAR_W-1:0] c;
        logic              eot;
    } char_item_t;

    // row of the directed table; lit marks a result typed in by hand
    typedef struct packed {
        logic [CHAR_W-1:0] c;
        logic              eot;
        logic              lit;
        result_t           want;
    } dir_row_t;

    // primitive letters, indexed by their base type code
    localparam logic [CHAR_W-1:0] PRIM_CHARS [8] = '{CH_B, CH_C, CH_D, CH_F,
                                                     CH_I, CH_J, CH_S, CH_Z};

    localparam result_t R_NONE = '0;

    function automatic result_t err_result(input logic [ERR_W-1:0] code);
        result_t r;
        r     = '0;
        r.ev  = EV_ERR;
        r.err = code;
        return r;
    endfunction

    // directed part: extremes of the bytes, primitive, array and class paths and the special cases
    localparam int unsigned DIRECTED_ROWS = 27;
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        // no opening parenthesis, then the error holds up to the end mark
        '{8'h41,    1'b0, 1'b1, err_result(ERR_NO_OPEN)},
        '{CH_CLOSE, 1'b1, 1'b1, err_result(ERR_NO_OPEN)},
        // fresh descriptor straight after the end mark
        '{CH_OPEN,  1'b0, 1'b1, R_NONE},
        '{CH_B,     1'b0, 1'b0, R_NONE},
        '{CH_Z,     1'b0, 1'b0, R_NONE},
        // two-deep array of a class whose name holds the extreme byte values
        '{CH_ARRAY, 1'b0, 1'b0, R_NONE},
        '{CH_ARRAY, 1'b0, 1'b0, R_NONE},
        '{CH_CLASS, 1'b0, 1'b0, R_NONE},
        '{8'hFF,    1'b0, 1'b0, R_NONE},
        '{8'h00,    1'b0, 1'b0, R_NONE},
        '{CH_SEMI,  1'b0, 1'b0, R_NONE},
        // class return type
        '{CH_CLOSE, 1'b0, 1'b0, R_NONE},
        '{CH_CLASS, 1'b0, 1'b0, R_NONE},
        '{8'h78,    1'b0, 1'b0, R_NONE},
        '{CH_SEMI,  1'b0, 1'b0, R_NONE},
        // byte after a complete descriptor
        '{CH_VOID,  1'b1, 1'b1, err_result(ERR_TRAILING)},
        // array bracket closed by the parameter list
        '{CH_OPEN,  1'b0, 1'b0, R_NONE},
        '{CH_ARRAY, 1'b0, 1'b0, R_NONE},
        '{CH_CLOSE, 1'b1, 1'b1, err_result(ERR_BAD_CHAR)},
        // empty class name
        '{CH_OPEN,  1'b0, 1'b0, R_NONE},
        '{CH_CLASS, 1'b0, 1'b0, R_NONE},
        '{CH_SEMI,  1'b1, 1'b1, err_result(ERR_BAD_CHAR)},
        // array of void as return type
        '{CH_OPEN,  1'b0, 1'b0, R_NONE},
        '{CH_CLOSE, 1'b0, 1'b0, R_NONE},
        '{CH_ARRAY, 1'b0, 1'b0, R_NONE},
        '{CH_VOID,  1'b1, 1'b1, err_result(ERR_BAD_CHAR)},
        // end mark before the descriptor is complete
        '{CH_OPEN,  1'b1, 1'b1, err_result(ERR_EARLY)}
    };

    // clock, reset and block ports; the inputs are known from time zero
    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_char_code   = '0;
    logic               s_end_of_text = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [EVENT_W-1:0] m_event_res;
    logic [BTYPE_W-1:0] m_base_type;
    logic [COUNT_W-1:0] m_array_depth;
    logic [COUNT_W-1:0] m_param_index;
    logic [COUNT_W-1:0] m_name_length;
    logic [ERR_W-1:0]   m_error_code;

    // predictor state
    grammar_phase_e     cur_phase;
    logic [COUNT_W-1:0] brackets;
    logic [COUNT_W-1:0] params_done;
    logic [COUNT_W-1:0] name_len;
    logic [ERR_W-1:0]   held_code;

    // results still owed by the block, oldest first
    result_t    pending_results [$];
    // descriptor being assembled before it is sent
    char_item_t seq_q [$];

    int unsigned fail_count      = 0;
    int unsigned chars_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned valid_seen      = 0;
    int unsigned errors_seen     = 0;
    int unsigned idle_cycles     = 0;
    logic        sender_burst    = 1'b0;
    logic        recv_burst      = 1'b0;
    logic        long_hold_done  = 1'b0;

    always #2 aclk = ~aclk;

    method_descriptor_parser u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_base_type   (m_base_type),
        .m_array_depth (m_array_depth),
        .m_param_index (m_param_index),
        .m_name_length (m_name_length),
        .m_error_code  (m_error_code)
    );

    // ---------------------------------------------------------------- predictor

    function automatic void reset_grammar();
        cur_phase   = PHASE_OPEN;
        brackets    = '0;
        params_done = '0;
        name_len    = '0;
        held_code   = ERR_NONE;
    endfunction

    // enter the error phase and hold the code until the end mark
    function automatic result_t flag_error(input logic [ERR_W-1:0] code);
        cur_phase = PHASE_ERR;
        held_code = code;
        return err_result(code);
    endfunction

    // a parameter or the return type has just finished
    function automatic result_t close_type(input logic is_ret, input logic [BTYPE_W-1:0] bt,
                                           input logic [COUNT_W-1:0] nlen);
        result_t r;
        r       = '0;
        r.bt    = bt;
        r.depth = brackets;
        r.nlen  = nlen;
        if (is_ret) begin
            cur_phase = PHASE_DONE;
            r.ev      = EV_RET;
        end else begin
            // the parameter past the limit is refused, counters left as they are
            if (params_done >= MAX_PARAMS_DEF)
                return flag_error(ERR_PARAMS);
            r.ev        = EV_PARAM;
            r.idx       = params_done;
            params_done = params_done + 1'b1;
            cur_phase   = PHASE_PARAMS;
        end
        brackets = '0;
        name_len = '0;
        return r;
    endfunction

    // byte where a field type may start
    function automatic result_t type_start(input logic [CHAR_W-1:0] c, input logic is_ret);
        for (int i = 0; i < 8; i++) begin
            if (c == PRIM_CHARS[i])
                return close_type(is_ret, BTYPE_W'(i), '0);
        end
        if (c == CH_ARRAY) begin
            if (brackets >= MAX_ARRAY_DEPTH_DEF)
                return flag_error(ERR_DEEP);
            brackets = brackets + 1'b1;
            return R_NONE;
        end
        if (c == CH_CLASS) begin
            name_len  = '0;
            cur_phase = is_ret ? PHASE_RNAME : PHASE_PNAME;
            return R_NONE;
        end
        return flag_error(ERR_BAD_CHAR);
    endfunction

    // byte inside a class name; anything but the semicolon counts
    function automatic result_t name_byte(input logic [CHAR_W-1:0] c, input logic is_ret);
        if (c == CH_SEMI) begin
            if (name_len == 0)
                return flag_error(ERR_BAD_CHAR);
            return close_type(is_ret, BT_CLASS, name_len);
        end
        if (name_len >= MAX_NAME_CHARS_DEF)
            return flag_error(ERR_NAME_LONG);
        name_len = name_len + 1'b1;
        return R_NONE;
    endfunction

    // expected result of one descriptor byte
    function automatic result_t descr_step(input logic [CHAR_W-1:0] c, input logic eot);
        result_t r;
        r = R_NONE;
        case (cur_phase)
            PHASE_OPEN: begin
                if (c == CH_OPEN)
                    cur_phase = PHASE_PARAMS;
                else
                    r = flag_error(ERR_NO_OPEN);
            end
            PHASE_PARAMS: begin
                if (c == CH_CLOSE) begin
                    if (brackets != 0)
                        r = flag_error(ERR_BAD_CHAR);
                    else
                        cur_phase = PHASE_RET;
                end else begin
                    r = type_start(c, 1'b0);
                end
            end
            PHASE_PNAME: r = name_byte(c, 1'b0);
            PHASE_RET: begin
                if (c == CH_VOID) begin
                    if (brackets != 0)
                        r = flag_error(ERR_BAD_CHAR);
                    else
                        r = close_type(1'b1, BT_VOID, '0);
                end else begin
                    r = type_start(c, 1'b1);
                end
            end
            PHASE_RNAME: r = name_byte(c, 1'b1);
            PHASE_DONE:  r = flag_error(ERR_TRAILING);
            default:     r = err_result(held_code);
        endcase
        // end mark: early end unless already finished or failed, then back to reset
        if (eot) begin
            if (cur_phase != PHASE_DONE && cur_phase != PHASE_ERR)
                r = err_result(ERR_EARLY);
            reset_grammar();
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- sender

    // offer one request from a falling edge, wait for the handshake, predict its result
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot,
                             input logic use_lit, input result_t lit);
        int unsigned gap;
        result_t     want;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        // predictor state moves on for every request, hand-typed rows included
        want = descr_step(c, eot);
        pending_results.push_back(use_lit ? lit : want);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic push_byte(input logic [CHAR_W-1:0] c);
        seq_q.push_back('{c: c, eot: 1'b0});
    endtask

    // random byte for a class name, never the terminating semicolon
    function automatic logic [CHAR_W-1:0] name_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        return (c == CH_SEMI) ? CHAR_W'($urandom_range(0, 8'h3A)) : c;
    endfunction

    // one field type: mostly plain, some arrays, some short class names
    task automatic add_type();
        int unsigned depth;
        int unsigned len;
        depth = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (depth) push_byte(CH_ARRAY);
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 6);
            push_byte(CH_CLASS);
            repeat (len) push_byte(name_char());
            push_byte(CH_SEMI);
        end else begin
            push_byte(PRIM_CHARS[$urandom_range(0, 7)]);
        end
    endtask

    // well-formed descriptor with random content, end mark on the last byte
    task automatic add_descriptor();
        int unsigned n;
        n = $urandom_range(0, 5);
        push_byte(CH_OPEN);
        repeat (n) add_type();
        push_byte(CH_CLOSE);
        if ($urandom_range(0, 3) == 0)
            push_byte(CH_VOID);
        else
            add_type();
        seq_q[seq_q.size()-1].eot = 1'b1;
    endtask

    // limit cases: deepest array with the longest name then one bracket too many,
    // a name one byte too long, and one parameter past the limit
    task automatic build_limit_case(input int unsigned which);
        push_byte(CH_OPEN);
        case (which)
            0: begin
                repeat (MAX_ARRAY_DEPTH_DEF) push_byte(CH_ARRAY);
                push_byte(CH_CLASS);
                repeat (MAX_NAME_CHARS_DEF) push_byte(name_char());
                push_byte(CH_SEMI);
                repeat (MAX_ARRAY_DEPTH_DEF + 1) push_byte(CH_ARRAY);
            end
            1: begin
                push_byte(CH_CLASS);
                repeat (MAX_NAME_CHARS_DEF + 1) push_byte(name_char());
            end
            default: begin
                repeat (MAX_PARAMS_DEF + 1) push_byte(PRIM_CHARS[$urandom_range(0, 7)]);
            end
        endcase
        seq_q[seq_q.size()-1].eot = 1'b1;
    endtask

    task automatic flush_seq();
        foreach (seq_q[i])
            send_char(seq_q[i].c, seq_q[i].eot, 1'b0, R_NONE);
        seq_q.delete();
    endtask

    // stimulus: reset, directed table, random descriptors with limit cases, drain
    initial begin
        int unsigned ordinary_chars;
        int unsigned limit_cases_done;
        int unsigned pick;
        int unsigned n;
        int unsigned idx;
        ordinary_chars   = 0;
        limit_cases_done = 0;
        reset_grammar();
        // reset held low from time zero, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_char(DIRECTED[i].c, DIRECTED[i].eot, DIRECTED[i].lit, DIRECTED[i].want);

        while (ordinary_chars < RANDOM_CHARS) begin
            if (limit_cases_done < 3 && ordinary_chars >= (limit_cases_done + 1) * 300) begin
                build_limit_case(limit_cases_done);
                limit_cases_done++;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    add_descriptor();
                end else if (pick < 18) begin
                    // broken descriptor
                    add_descriptor();
                    case ($urandom_range(0, 3))
                        0: begin
                            idx = $urandom_range(0, seq_q.size() - 1);
                            seq_q[idx].c = CHAR_W'($urandom_range(0, 255));
                        end
                        1: begin
                            // cut short, end mark moves to the new last byte
                            n = $urandom_range(1, seq_q.size() - 1);
                            while (seq_q.size() > n)
                                seq_q.delete(seq_q.size() - 1);
                            seq_q[seq_q.size()-1].eot = 1'b1;
                        end
                        2: begin
                            seq_q[seq_q.size()-1].eot = 1'b0;
                            repeat ($urandom_range(1, 3))
                                push_byte(CHAR_W'($urandom_range(0, 255)));
                            seq_q[seq_q.size()-1].eot = 1'b1;
                        end
                        default: begin
                            // no end mark, runs on into the next descriptor
                            seq_q[seq_q.size()-1].eot = 1'b0;
                        end
                    endcase
                end else begin
                    // noise with scattered end marks
                    repeat ($urandom_range(1, 6))
                        seq_q.push_back('{c: CHAR_W'($urandom_range(0, 255)),
                                          eot: ($urandom_range(0, 3) == 0)});
                    seq_q[seq_q.size()-1].eot = 1'b1;
                end
                ordinary_chars += seq_q.size();
            end
            if ($urandom_range(0, 7) == 0)
                sender_burst = ~sender_burst;
            flush_seq();
        end
        s_valid <= 1'b0;

        // wait for every owed result, then DRAIN_CYCLES more for strays
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d results checked: %0d valid descriptors, %0d errors",
                 chars_sent, results_checked, valid_seen, errors_seen);
        $display("directed table, random descriptors and limits of depth, name and count");
        if (fail_count == 0)
            $display("tb_method_descriptor_parser: clean");
        else
            $display("tb_method_descriptor_parser: errors");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        result_t     want;
        int unsigned gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            // one long stall so the queue fills and the input backs up
            if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                gap            = gap + LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: event_res %0d error_code %0d",
                       m_event_res, m_error_code);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_event_res !== want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, m_event_res);
                    fail_count++;
                end
                if (m_base_type !== want.bt) begin
                    $error("base_type: expected %0d, got %0d", want.bt, m_base_type);
                    fail_count++;
                end
                if (m_array_depth !== want.depth) begin
                    $error("array_depth: expected %0d, got %0d", want.depth, m_array_depth);
                    fail_count++;
                end
                if (m_param_index !== want.idx) begin
                    $error("param_index: expected %0d, got %0d", want.idx, m_param_index);
                    fail_count++;
                end
                if (m_name_length !== want.nlen) begin
                    $error("name_length: expected %0d, got %0d", want.nlen, m_name_length);
                    fail_count++;
                end
                if (m_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                    fail_count++;
                end
                if (want.ev == EV_RET)
                    valid_seen++;
                if (want.ev == EV_ERR)
                    errors_seen++;
            end
            results_checked++;
            @(negedge aclk);
        end
    end

    // ---------------------------------------------------------------- watchdog

    // ends the run when neither channel has moved for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", idle_cycles);
            $display("tb_method_descriptor_parser: errors");
            $finish;
        end
    end

endmodule
